// File: rtl/vector_angle_degrees_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vector angle unit
// Clocked property shorthands shared by the RTL files that check themselves.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ANGLE_DEGREES_UNIT_MACROS_SVH
`define VECTOR_ANGLE_DEGREES_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VAD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector angle unit: check failed");

// The consequent is checked after the antecedent, delayed by the argument n.
`define VAD_ASSERT_AFTER(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error("vector angle unit: latency check failed");

`endif

// File: rtl/vad_pkg.sv
// ----------------------------------------------------------------------------
// Vector angle package
// Types, widths and the arctangent table shared by the vector angle unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vad_pkg;

    localparam int DW        = 64;
    localparam int NORM_MSB  = 59;
    localparam int Z_W       = 26;
    localparam int ANG_FRAC  = 16;
    localparam int ANG_W     = 8;
    localparam int TABLE_LEN = 32;
    localparam int TAB_AW    = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DESIRED_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DESIRED_Z = 1'b1;

    localparam logic [ANG_W-1:0] ANG_ZERO = 8'd0;
    localparam logic [ANG_W-1:0] ANG_90   = 8'd90;
    localparam logic [ANG_W-1:0] ANG_180  = 8'd180;

    localparam logic signed [Z_W-1:0] Z_90  = 26'sd5898240;
    localparam logic signed [Z_W-1:0] Z_180 = 26'sd11796480;

    localparam logic signed [Z_W-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0
    };

    typedef struct packed {
        logic             valid;
        logic             fixed;
        logic             degenerate;
        logic [ANG_W-1:0] fixed_angle;
    } vad_side_t;

    typedef struct packed {
        logic signed [DW-1:0]  x;
        logic signed [DW-1:0]  y;
        logic signed [Z_W-1:0] z;
    } vad_vec_t;

endpackage

`default_nettype wire

// File: rtl/vad_cordic_stage.sv
// ----------------------------------------------------------------------------
// Vector angle CORDIC stage
// One registered vectoring micro-rotation with its angle accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module vad_cordic_stage #(
    parameter int STAGE = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire vad_pkg::vad_side_t side_in,
    input  wire vad_pkg::vad_vec_t  vec_in,
    output vad_pkg::vad_side_t      side_out,
    output vad_pkg::vad_vec_t       vec_out
);

    import vad_pkg::*;

    localparam logic [TAB_AW-1:0] TAB_IDX = TAB_AW'(STAGE);

    vad_side_t side_reg;
    vad_vec_t  vec_reg;
    vad_vec_t  vec_next;
    logic signed [DW-1:0] x_shift;
    logic signed [DW-1:0] y_shift;

    assign x_shift = vec_in.x >>> STAGE;
    assign y_shift = vec_in.y >>> STAGE;

    always_comb
    begin
        if (!vec_in.y[DW-1])
        begin
            vec_next.x = vec_in.x + y_shift;
            vec_next.y = vec_in.y - x_shift;
            vec_next.z = vec_in.z + ATAN_DEG_Q16[TAB_IDX];
        end
        else
        begin
            vec_next.x = vec_in.x - y_shift;
            vec_next.y = vec_in.y + x_shift;
            vec_next.z = vec_in.z - ATAN_DEG_Q16[TAB_IDX];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign side_out = side_reg;
    assign vec_out  = vec_reg;

endmodule

`default_nettype wire

// File: rtl/vector_angle_degrees_unit.sv
// ----------------------------------------------------------------------------
// Vector angle unit
// Unsigned angle in whole degrees between a sample (x, z) and a desired
// vector, computed as atan2(|cross|, dot) by a pipelined vectoring CORDIC.
//
// Channel   Ports                                   Handshake
// input     accel_x, accel_z                        start high, busy low
// result    angle_deg, degenerate                   done strobe, one cycle
// config    cfg_we, cfg_index, cfg_data             write on cfg_we high
//
// A beat can enter in every cycle; busy is always low.
// Pipeline registers: products, sum, operand setup, two normalizing
// stages, one stage per CORDIC rotation and an output register.
// Reset clears the valid bits and loads desired_x = 0, desired_z = 256.
// The receiver cannot stall, so the pipeline advances in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector_angle_degrees_unit_macros.svh"

module vector_angle_degrees_unit #(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 20
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [SAMPLE_BITS-1:0]     accel_x,
    input  wire logic signed [SAMPLE_BITS-1:0]     accel_z,
    output logic                                   done,
    output logic [vad_pkg::ANG_W-1:0]              angle_deg,
    output logic                                   degenerate,
    input  wire logic                              cfg_we,
    input  wire logic [vad_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [SAMPLE_BITS-1:0]            cfg_data
);

    import vad_pkg::*;

    localparam int PROD_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W   = PROD_W + 1;
    localparam int LATENCY = CORDIC_STAGES + 6;

    logic signed [SAMPLE_BITS-1:0] desired_x_reg;
    logic signed [SAMPLE_BITS-1:0] desired_z_reg;

    logic                     s1_valid_reg;
    logic                     s1_degen_reg;
    logic signed [PROD_W-1:0] p_xx_reg;
    logic signed [PROD_W-1:0] p_zz_reg;
    logic signed [PROD_W-1:0] p_xz_reg;
    logic signed [PROD_W-1:0] p_zx_reg;

    logic                    s2_valid_reg;
    logic                    s2_degen_reg;
    logic signed [SUM_W-1:0] dot_reg;
    logic signed [SUM_W-1:0] crs_reg;

    vad_side_t s3_side_reg;
    vad_side_t s3_side_next;
    vad_vec_t  s3_vec_reg;
    vad_vec_t  s3_vec_next;
    vad_side_t s4_side_reg;
    vad_vec_t  s4_vec_reg;
    vad_vec_t  s4_vec_next;
    vad_side_t s5_side_reg;
    vad_vec_t  s5_vec_reg;
    vad_vec_t  s5_vec_next;

    vad_side_t cs_side [CORDIC_STAGES+1];
    vad_vec_t  cs_vec  [CORDIC_STAGES+1];

    logic             done_reg;
    logic [ANG_W-1:0] angle_reg;
    logic [ANG_W-1:0] angle_next;
    logic             degen_reg;

    logic signed [SUM_W-1:0] crs_abs;
    logic signed [SUM_W-1:0] dot_neg;
    logic                    accept;

    function automatic vad_vec_t norm_step(vad_vec_t v, int unsigned k);
        logic [DW-1:0] ored;
        ored = v.x | v.y;
        if ((ored >> (NORM_MSB + 1 - k)) == '0)
        begin
            v.x = v.x << k;
            v.y = v.y << k;
        end
        return v;
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desired_x_reg <= '0;
            desired_z_reg <= SAMPLE_BITS'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DESIRED_X: desired_x_reg <= cfg_data;
                REG_DESIRED_Z: desired_z_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_side_reg  <= '0;
            s4_side_reg  <= '0;
            s5_side_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_side_reg  <= s3_side_next;
            s4_side_reg  <= s3_side_reg;
            s5_side_reg  <= s4_side_reg;
            done_reg     <= cs_side[CORDIC_STAGES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_degen_reg <= ((accel_x == '0) && (accel_z == '0))
                     || ((desired_x_reg == '0) && (desired_z_reg == '0));
        p_xx_reg     <= PROD_W'(accel_x) * PROD_W'(desired_x_reg);
        p_zz_reg     <= PROD_W'(accel_z) * PROD_W'(desired_z_reg);
        p_xz_reg     <= PROD_W'(accel_x) * PROD_W'(desired_z_reg);
        p_zx_reg     <= PROD_W'(accel_z) * PROD_W'(desired_x_reg);
        s2_degen_reg <= s1_degen_reg;
        dot_reg      <= SUM_W'(p_xx_reg) + SUM_W'(p_zz_reg);
        crs_reg      <= SUM_W'(p_xz_reg) - SUM_W'(p_zx_reg);
        s3_vec_reg   <= s3_vec_next;
        s4_vec_reg   <= s4_vec_next;
        s5_vec_reg   <= s5_vec_next;
        angle_reg    <= angle_next;
        degen_reg    <= cs_side[CORDIC_STAGES].degenerate;
    end

    assign crs_abs = crs_reg[SUM_W-1] ? -crs_reg : crs_reg;
    assign dot_neg = -dot_reg;

    always_comb
    begin
        s3_side_next.valid      = s2_valid_reg;
        s3_side_next.degenerate = s2_degen_reg;
        s3_side_next.fixed      = s2_degen_reg || (crs_reg == '0) || (dot_reg == '0);
        if (s2_degen_reg)
        begin
            s3_side_next.fixed_angle = ANG_ZERO;
        end
        else if (crs_reg == '0)
        begin
            s3_side_next.fixed_angle = (dot_reg > 0) ? ANG_ZERO : ANG_180;
        end
        else
        begin
            s3_side_next.fixed_angle = ANG_90;
        end

        if (dot_reg[SUM_W-1])
        begin
            s3_vec_next.x = DW'(crs_abs);
            s3_vec_next.y = DW'(dot_neg);
            s3_vec_next.z = Z_90;
        end
        else
        begin
            s3_vec_next.x = DW'(dot_reg);
            s3_vec_next.y = DW'(crs_abs);
            s3_vec_next.z = '0;
        end
    end

    always_comb
    begin
        s4_vec_next = norm_step(norm_step(norm_step(s3_vec_reg, 32), 16), 8);
        s5_vec_next = norm_step(norm_step(norm_step(s4_vec_reg, 4), 2), 1);
    end

    assign cs_side[0] = s5_side_reg;
    assign cs_vec[0]  = s5_vec_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        vad_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .side_in  (cs_side[i]),
            .vec_in   (cs_vec[i]),
            .side_out (cs_side[i+1]),
            .vec_out  (cs_vec[i+1])
        );
    end

    always_comb
    begin
        if (cs_side[CORDIC_STAGES].fixed)
        begin
            angle_next = cs_side[CORDIC_STAGES].fixed_angle;
        end
        else if (cs_vec[CORDIC_STAGES].z[Z_W-1])
        begin
            angle_next = ANG_ZERO;
        end
        else if (cs_vec[CORDIC_STAGES].z > Z_180)
        begin
            angle_next = ANG_180;
        end
        else
        begin
            angle_next = cs_vec[CORDIC_STAGES].z[ANG_FRAC+ANG_W-1:ANG_FRAC];
        end
    end

    assign done       = done_reg;
    assign angle_deg  = angle_reg;
    assign degenerate = degen_reg;

    `VAD_ASSERT_NOW(a_angle_range, done, angle_deg <= ANG_180)
    `VAD_ASSERT_NOW(a_degen_zero, done && degenerate, angle_deg == ANG_ZERO)
    `VAD_ASSERT_AFTER(a_latency_hit, start && !busy, LATENCY, done)
    `VAD_ASSERT_AFTER(a_latency_miss, !(start && !busy), LATENCY, !done)

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector angle unit testbench
// Sends accelerometer samples against several desired vectors, starting with
// a short scripted list of axis-aligned, extreme and degenerate vectors, then
// random phases. Each result beat is checked against a scripted value or an
// in-bench fixed-point CORDIC predictor, with random idle cycles on the input side.
// ----------------------------------------------------------------------------
module tb_top;

    import vad_pkg::*;

    localparam int SAMPLE_BITS   = 16;
    localparam int CORDIC_STAGES = 20;
    localparam int LATENCY       = CORDIC_STAGES + 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 216;
    localparam int QUIET_PHASE   = 3;
    localparam int NUM_ROWS      = 31;

    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7fff;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [ANG_W-1:0] angle;
        logic             degen;
    } angle_beat_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        sample_t              a;
        sample_t              b;
        logic                 typed;
        logic [ANG_W-1:0]     angle;
        logic                 degen;
    } script_row_t;

    localparam script_row_t SCRIPT [NUM_ROWS] = '{
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd0,      16'sd0,     1'b1, ANG_ZERO, 1'b1},
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd0,      16'sd1,     1'b1, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd0,      -16'sd1,    1'b1, ANG_180,  1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd0,      S_MAX,      1'b1, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd0,      S_MIN,      1'b1, ANG_180,  1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, S_MAX,       16'sd0,     1'b1, ANG_90,   1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, S_MIN,       16'sd0,     1'b1, ANG_90,   1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd1,      16'sd1,     1'b0, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, -16'sd1,     -16'sd1,    1'b0, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, S_MAX,       S_MIN,      1'b0, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, S_MIN,       S_MAX,      1'b0, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd1,      S_MIN,      1'b0, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, S_MIN,       16'sd1,     1'b0, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd12345,  -16'sd5432, 1'b0, ANG_ZERO, 1'b0},
        '{ROW_WRITE,  REG_DESIRED_X, S_MIN,       16'sd0,     1'b0, ANG_ZERO, 1'b0},
        '{ROW_WRITE,  REG_DESIRED_Z, 16'sd0,      16'sd0,     1'b0, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd1,      16'sd0,     1'b1, ANG_180,  1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, -16'sd1,     16'sd0,     1'b1, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd0,      16'sd7,     1'b1, ANG_90,   1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, -16'sd7,     16'sd3,     1'b0, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, S_MAX,       S_MAX,      1'b0, ANG_ZERO, 1'b0},
        '{ROW_WRITE,  REG_DESIRED_X, 16'sd0,      16'sd0,     1'b0, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd100,    -16'sd100,  1'b1, ANG_ZERO, 1'b1},
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd0,      16'sd0,     1'b1, ANG_ZERO, 1'b1},
        '{ROW_WRITE,  REG_DESIRED_X, S_MAX,       16'sd0,     1'b0, ANG_ZERO, 1'b0},
        '{ROW_WRITE,  REG_DESIRED_Z, S_MAX,       16'sd0,     1'b0, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, S_MIN,       S_MIN,      1'b1, ANG_180,  1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, S_MAX,       S_MAX,      1'b1, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd1,      -16'sd1,    1'b1, ANG_90,   1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, 16'sd3,      -16'sd1,    1'b0, ANG_ZERO, 1'b0},
        '{ROW_SAMPLE, REG_DESIRED_X, -16'sd2,     16'sd9,     1'b0, ANG_ZERO, 1'b0}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    sample_t              accel_x   = '0;
    sample_t              accel_z   = '0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_DESIRED_X;
    logic [SAMPLE_BITS-1:0] cfg_data = '0;
    logic                 busy;
    logic                 done;
    logic [ANG_W-1:0]     angle_deg;
    logic                 degenerate;

    sample_t     target_x = 16'sd0;
    sample_t     target_z = 16'sd256;
    angle_beat_t pending_angles [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;

    vector_angle_degrees_unit #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .accel_x    (accel_x),
        .accel_z    (accel_z),
        .done       (done),
        .angle_deg  (angle_deg),
        .degenerate (degenerate),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic angle_beat_t predict_angle(input sample_t ax, input sample_t az,
                                                  input sample_t dx, input sample_t dz);
        longint          sax;
        longint          saz;
        longint          sdx;
        longint          sdz;
        longint          dot;
        longint          crs;
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        longint unsigned ux;
        longint unsigned uy;
        int              k;
        angle_beat_t     res;
        sax = ax;
        saz = az;
        sdx = dx;
        sdz = dz;
        res.angle = ANG_ZERO;
        res.degen = 1'b0;
        if ((sax == 0 && saz == 0) || (sdx == 0 && sdz == 0))
        begin
            res.degen = 1'b1;
            return res;
        end
        dot = sax * sdx + saz * sdz;
        crs = sax * sdz - saz * sdx;
        if (crs < 0)
            crs = -crs;
        if (crs == 0)
            res.angle = (dot > 0) ? ANG_ZERO : ANG_180;
        else if (dot == 0)
            res.angle = ANG_90;
        else
        begin
            z = 0;
            if (dot < 0)
            begin
                x = crs;
                y = -dot;
                z = Z_90;
            end
            else
            begin
                x = dot;
                y = crs;
            end
            ux = x;
            uy = y;
            while ((((ux | uy) >> NORM_MSB) == 0) && ((ux | uy) != 0))
            begin
                ux = ux << 1;
                uy = uy << 1;
            end
            x = ux;
            y = uy;
            for (k = 0; k < CORDIC_STAGES; k++)
            begin
                xs = x >>> k;
                ys = y >>> k;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_DEG_Q16[k];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_DEG_Q16[k];
                end
            end
            if (z < 0)
                z = 0;
            if (z > Z_180)
                z = Z_180;
            res.angle = ANG_W'(z >> ANG_FRAC);
        end
        return res;
    endfunction

    function automatic sample_t extreme_value();
        sample_t picks [5];
        picks = '{S_MIN, -16'sd1, 16'sd0, 16'sd1, S_MAX};
        return picks[$urandom_range(4)];
    endfunction

    function automatic sample_t small_value(input int span);
        return sample_t'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic sample_t pick_desired(input int mode);
        case (mode)
            1:       return extreme_value();
            2:       return small_value(4);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic make_sample(output sample_t sx, output sample_t sz);
        int      sel;
        int      mult;
        sample_t rnd;
        sel  = $urandom_range(99);
        mult = int'($urandom_range(1, 64)) * ($urandom_range(1) ? 1 : -1);
        rnd  = sample_t'($urandom);
        if (sel < 45)
        begin
            sx = sample_t'($urandom);
            sz = sample_t'($urandom);
        end
        else if (sel < 60)
        begin
            sx = small_value(16);
            sz = small_value(16);
        end
        else if (sel < 70)
        begin
            sx = extreme_value();
            sz = extreme_value();
        end
        else if (sel < 78)
        begin
            sx = sample_t'(target_x * mult);
            sz = sample_t'(target_z * mult);
        end
        else if (sel < 86)
        begin
            sx = sample_t'(-target_z * mult);
            sz = sample_t'(target_x * mult);
        end
        else if (sel < 94)
        begin
            sx = $urandom_range(1) ? rnd : 16'sd0;
            sz = (sx == 16'sd0) ? rnd : 16'sd0;
        end
        else if (sel < 97)
        begin
            sx = 16'sd0;
            sz = 16'sd0;
        end
        else
        begin
            sx = rnd;
            sz = sample_t'(rnd + small_value(3));
        end
    endtask

    task automatic idle_gap(input int cycles);
        start   <= 1'b0;
        accel_x <= sample_t'($urandom);
        accel_z <= sample_t'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_pause();
        if (!quiet && $urandom_range(99) < 10)
            idle_gap($urandom_range(1, 3));
    endtask

    task automatic send_sample(input sample_t sx, input sample_t sz,
                               input bit typed, input angle_beat_t want);
        start   <= 1'b1;
        accel_x <= sx;
        accel_z <= sz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_angles.push_back(typed ? want : predict_angle(sx, sz, target_x, target_z));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input sample_t val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_DESIRED_X: target_x = val;
            REG_DESIRED_Z: target_z = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
    endtask

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    always @(posedge clk)
    begin
        angle_beat_t want;
        if (rst_n && done)
        begin
            if (pending_angles.size() == 0)
                log_mismatch($sformatf("result beat with nothing pending, angle %0d degen %0b",
                                       angle_deg, degenerate));
            else
            begin
                want = pending_angles.pop_front();
                if (angle_deg !== want.angle)
                    log_mismatch($sformatf("angle_deg expected %0d got %0d",
                                           want.angle, angle_deg));
                if (degenerate !== want.degen)
                    log_mismatch($sformatf("degenerate expected %0b got %0b",
                                           want.degen, degenerate));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        script_row_t row;
        angle_beat_t want;
        sample_t     sx;
        sample_t     sz;
        int          ph;
        int          n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (n = 0; n < NUM_ROWS; n++)
        begin
            row = SCRIPT[n];
            if (row.kind == ROW_WRITE)
                set_register(row.reg_idx, row.a);
            else
            begin
                maybe_pause();
                want.angle = row.angle;
                want.degen = row.degen;
                send_sample(row.a, row.b, row.typed, want);
            end
        end
        want = '0;
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            quiet = (ph == QUIET_PHASE);
            set_register(REG_DESIRED_X, pick_desired(ph % 4));
            set_register(REG_DESIRED_Z, pick_desired(ph % 4));
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                make_sample(sx, sz);
                maybe_pause();
                send_sample(sx, sz, 1'b0, want);
            end
        end
        drain();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/vad_pkg.sv
rtl/vad_cordic_stage.sv
rtl/vector_angle_degrees_unit.sv
bench/tb_top.sv
